// File: rtl/tss_pkg.sv
// shared types and constants for the time slice task scheduler
package tss_pkg;

   localparam int TASK_SLOTS_DEFAULT = 16;
   localparam int TICK_WIDTH_DEFAULT = 16;

   // the present register covers this many slots
   localparam int PRESENT_W = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_DATA_W-1:0] SLICE_TICKS_RESET  = 16'd10;
   localparam logic [CSR_DATA_W-1:0] TASK_PRESENT_RESET = 16'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_PRESENT = 2'd1;

   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_YIELD     = 2'd1;
   localparam logic [1:0] OP_SET_STATE = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] slot_index;
      logic       make_runnable;
   } req_type;

   typedef struct packed {
      logic [3:0]  running_slot;
      logic        switched;
      logic [15:0] ticks_remaining;
   } rsp_type;

   // per-cell commands from the controller
   typedef struct packed {
      logic dec;
      logic set_run;
      logic run_val;
      logic reload;
      logic reload_all;
   } cell_cmd_type;

   // search wave control handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
   } probe_ctl_type;

endpackage

// File: rtl/time_slice_task_scheduler_core.sv
// time slice task scheduler top level: controller and row of slot cells
//
// An item is taken when start is high and busy is low. Every item gives one
// result, shown on rsp_item for one cycle with rsp_valid high; the receiver
// cannot hold it off. Ticks that do not run a slice out, set-state items and
// the unused opcode give their result in the cycle after they are taken.
// Ticks that run a slice out and yields start a search wave that walks the
// row of cells one slot per cycle; the result follows the wave, or a second
// wave when no slot qualifies and the counts of present slots are reloaded
// for it. busy is high during the wave and drops in the cycle the result
// is shown, so the next item can be taken then. Registers are written on
// the csr channel while busy is low; writing slice_ticks reloads every
// count. Reset gives slice_ticks 10, task_present 3, all slots runnable
// with full counts and slot 0 running.
module time_slice_task_scheduler_core #(
   parameter int TASK_SLOTS = tss_pkg::TASK_SLOTS_DEFAULT,
   parameter int TICK_WIDTH = tss_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tss_pkg::req_type               req_item,
   output logic                           rsp_valid,
   output tss_pkg::rsp_type               rsp_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tss_pkg::*;

   localparam int SLOT_W = $clog2(TASK_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN1 = 3'b010,
      ST_SCAN2 = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CSR_DATA_W-1:0]  slice_ff;
   logic [PRESENT_W-1:0]   present_ff;
   logic [SLOT_W-1:0]      cur_ff;
   logic [TICK_WIDTH-1:0]  cur_cnt_ff;
   logic                   launch_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   probe_ctl_type          p_ctl   [TASK_SLOTS+1];
   logic [SLOT_W-1:0]      p_pos   [TASK_SLOTS+1];
   logic [SLOT_W-1:0]      p_idx   [TASK_SLOTS+1];
   logic [TICK_WIDTH-1:0]  p_count [TASK_SLOTS+1];
   logic [TICK_WIDTH-1:0]  p_head  [TASK_SLOTS+1];
   cell_cmd_type           cmd     [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]  present;

   logic                   accept;
   logic                   csr_wr;
   logic                   wr_slice;
   logic                   is_tick;
   logic                   tick_dec;
   logic                   do_sched;
   logic                   tail_done;
   logic                   rescan;
   logic                   finish;
   logic [SLOT_W-1:0]      new_cur;
   logic [TICK_WIDTH-1:0]  new_cnt;
   logic [TICK_WIDTH-1:0]  reload_value;
   logic [TICK_WIDTH-1:0]  dec_cnt;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = start && !busy;
   assign csr_wr    = csr_valid && csr_ready;
   assign wr_slice  = csr_wr && (csr_index == CSR_SLICE_TICKS);

   assign is_tick  = accept && (req_item.opcode == OP_TICK);
   assign tick_dec = is_tick && (cur_cnt_ff != '0);
   assign dec_cnt  = cur_cnt_ff - 1'b1;
   assign do_sched = (accept && (req_item.opcode == OP_YIELD))
                  || (tick_dec && (cur_cnt_ff == TICK_WIDTH'(1)));

   assign tail_done = p_ctl[TASK_SLOTS].valid;
   assign rescan    = tail_done && (state_ff == ST_SCAN1) && !p_ctl[TASK_SLOTS].found;
   assign finish    = tail_done && !rescan;
   assign new_cur   = p_ctl[TASK_SLOTS].found ? p_idx[TASK_SLOTS] : '0;
   assign new_cnt   = p_ctl[TASK_SLOTS].found ? p_count[TASK_SLOTS] : p_head[TASK_SLOTS];

   assign reload_value = wr_slice ? TICK_WIDTH'(csr_data) : TICK_WIDTH'(slice_ff);

   // head of the search wave
   assign p_ctl[0]   = '{valid: launch_ff, found: 1'b0};
   assign p_pos[0]   = '0;
   assign p_idx[0]   = '0;
   assign p_count[0] = '0;
   assign p_head[0]  = '0;

   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      if (i < PRESENT_W) begin : g_pres
         assign present[i] = present_ff[i];
      end else begin : g_absent
         assign present[i] = 1'b0;
      end

      always_comb begin
         cmd[i].dec        = tick_dec && (cur_ff == SLOT_W'(i));
         cmd[i].set_run    = accept && (req_item.opcode == OP_SET_STATE)
                          && (32'(req_item.slot_index) == i);
         cmd[i].run_val    = req_item.make_runnable;
         cmd[i].reload     = wr_slice || rescan;
         cmd[i].reload_all = wr_slice;
      end

      tss_cell #(
         .TASK_SLOTS (TASK_SLOTS),
         .TICK_WIDTH (TICK_WIDTH),
         .SLOT_W     (SLOT_W)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd[i]),
         .reload_value    (reload_value),
         .present         (present[i]),
         .probe_ctl_in    (p_ctl[i]),
         .probe_pos_in    (p_pos[i]),
         .probe_idx_in    (p_idx[i]),
         .probe_count_in  (p_count[i]),
         .probe_head_in   (p_head[i]),
         .probe_ctl_out   (p_ctl[i+1]),
         .probe_pos_out   (p_pos[i+1]),
         .probe_idx_out   (p_idx[i+1]),
         .probe_count_out (p_count[i+1]),
         .probe_head_out  (p_head[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_sched) begin
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (rescan) begin
               state_in = ST_SCAN2;
            end else if (tail_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN2: begin
            if (tail_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slice_ff     <= SLICE_TICKS_RESET;
         present_ff   <= TASK_PRESENT_RESET;
         cur_ff       <= '0;
         cur_cnt_ff   <= TICK_WIDTH'(SLICE_TICKS_RESET);
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= do_sched || rescan;
         rsp_valid_ff <= 1'b0;
         if (wr_slice) begin
            slice_ff   <= csr_data;
            cur_cnt_ff <= TICK_WIDTH'(csr_data);
         end
         if (csr_wr && (csr_index == CSR_TASK_PRESENT)) begin
            present_ff <= csr_data;
         end
         if (tick_dec) begin
            cur_cnt_ff <= dec_cnt;
         end
         if (accept && !do_sched) begin
            rsp_valid_ff <= 1'b1;
         end
         if (finish) begin
            cur_ff       <= new_cur;
            cur_cnt_ff   <= new_cnt;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff.running_slot    <= 4'(new_cur);
         rsp_ff.switched        <= (new_cur != cur_ff);
         rsp_ff.ticks_remaining <= 16'(new_cnt);
      end else if (accept) begin
         rsp_ff.running_slot    <= 4'(cur_ff);
         rsp_ff.switched        <= 1'b0;
         rsp_ff.ticks_remaining <= tick_dec ? 16'(dec_cnt) : 16'(cur_cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/tss_cell.sv
// one task slot: runnable bit, slice count and one stage of the search wave
module tss_cell #(
   parameter int TASK_SLOTS = tss_pkg::TASK_SLOTS_DEFAULT,
   parameter int TICK_WIDTH = tss_pkg::TICK_WIDTH_DEFAULT,
   parameter int SLOT_W     = $clog2(TASK_SLOTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tss_pkg::cell_cmd_type   cmd,
   input  logic [TICK_WIDTH-1:0]   reload_value,
   input  logic                    present,
   input  tss_pkg::probe_ctl_type  probe_ctl_in,
   input  logic [SLOT_W-1:0]       probe_pos_in,
   input  logic [SLOT_W-1:0]       probe_idx_in,
   input  logic [TICK_WIDTH-1:0]   probe_count_in,
   input  logic [TICK_WIDTH-1:0]   probe_head_in,
   output tss_pkg::probe_ctl_type  probe_ctl_out,
   output logic [SLOT_W-1:0]       probe_pos_out,
   output logic [SLOT_W-1:0]       probe_idx_out,
   output logic [TICK_WIDTH-1:0]   probe_count_out,
   output logic [TICK_WIDTH-1:0]   probe_head_out
);
   import tss_pkg::*;

   logic                  run_ff;
   logic [TICK_WIDTH-1:0] count_ff;
   probe_ctl_type         ctl_ff;
   logic [SLOT_W-1:0]     pos_ff;
   logic [SLOT_W-1:0]     idx_ff;
   logic [TICK_WIDTH-1:0] cnt_ff;
   logic [TICK_WIDTH-1:0] head_ff;
   logic                  eligible;
   logic                  take;

   assign eligible = present && run_ff && (count_ff != '0);
   assign take     = !probe_ctl_in.found && eligible;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b1;
         count_ff <= TICK_WIDTH'(SLICE_TICKS_RESET);
         ctl_ff   <= '0;
      end else begin
         if (cmd.set_run) begin
            run_ff <= cmd.run_val;
         end
         if (cmd.reload && (cmd.reload_all || present)) begin
            count_ff <= reload_value;
         end else if (cmd.dec) begin
            count_ff <= count_ff - 1'b1;
         end
         ctl_ff.valid <= probe_ctl_in.valid;
         ctl_ff.found <= probe_ctl_in.found || eligible;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= SLOT_W'(probe_pos_in + 1'b1);
      idx_ff  <= take ? probe_pos_in : probe_idx_in;
      cnt_ff  <= take ? count_ff : probe_count_in;
      head_ff <= (probe_pos_in == '0) ? count_ff : probe_head_in;
   end

   assign probe_ctl_out   = ctl_ff;
   assign probe_pos_out   = pos_ff;
   assign probe_idx_out   = idx_ff;
   assign probe_count_out = cnt_ff;
   assign probe_head_out  = head_ff;

endmodule
